FILE: src/ssc_pkg.sv
// Package for the sensorless six-step commutator: item types, codes and
// constant tables shared by the core and the top level. No dependencies.
package ssc_pkg;

    // Input item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    // Commutation causes
    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_ZC      = 2'd1;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;
    localparam logic [1:0] CAUSE_START   = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DLY_SHIFT = 2'd1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [15:0] MAX_TICKS_RST = 16'd4000;
    localparam logic [3:0]  DLY_SHIFT_RST = 4'd4;

    // Steps
    localparam logic [2:0] STEP_OFF   = 3'd0;
    localparam logic [2:0] STEP_FIRST = 3'd1;
    localparam logic [2:0] STEP_LAST  = 3'd6;

    // Countdown takes the filtered delay divided by eight
    localparam int unsigned DLY_POST_SHIFT = 3;

    typedef struct packed {
        logic [1:0] kind;
        logic       comparator_out;
    } t_in_item;

    typedef struct packed {
        logic [2:0] step;
        logic [5:0] gate_pattern;
        logic       compare_polarity;
        logic [1:0] compare_channel;
        logic [1:0] commutation_cause;
    } t_out_item;

    typedef struct packed {
        logic [15:0] max_ticks;
        logic [3:0]  dly_shift;
    } t_cfg;

    // Back-EMF window filter
    localparam logic [5:0] WINDOW_TABLE [64] = '{
        6'h00, 6'h02, 6'h04, 6'h06, 6'h08, 6'h0A, 6'h0C, 6'h0E,
        6'h10, 6'h12, 6'h14, 6'h16, 6'h18, 6'h1A, 6'h1C, 6'h1E,
        6'h20, 6'h22, 6'h24, 6'h26, 6'h28, 6'h2A, 6'h2C, 6'h2E,
        6'h01, 6'h01, 6'h01, 6'h36, 6'h01, 6'h3A, 6'h3C, 6'h3E,
        6'h00, 6'h02, 6'h04, 6'h06, 6'h08, 6'h0A, 6'h0C, 6'h0E,
        6'h01, 6'h01, 6'h01, 6'h16, 6'h01, 6'h1A, 6'h1C, 6'h1E,
        6'h01, 6'h01, 6'h01, 6'h26, 6'h01, 6'h2A, 6'h2C, 6'h2E,
        6'h01, 6'h01, 6'h01, 6'h36, 6'h01, 6'h3A, 6'h3C, 6'h01
    };

    // Gate enables UH,UL,VH,VL,WH,WL from bit 5 down
    localparam logic [5:0] GATE_TABLE [8] = '{
        6'h00, 6'h24, 6'h21, 6'h09, 6'h18, 6'h12, 6'h06, 6'h00
    };

    // Polarity in bit 2, channel in bits 1..0
    localparam logic [2:0] SELECT_TABLE [8] = '{
        3'h0, 3'h2, 3'h5, 3'h0, 3'h6, 3'h1, 3'h4, 3'h0
    };

endpackage

FILE: src/ssc_dly_filt.sv
// Running-average phase delay filter for the commutator.
// Depends on ssc_pkg for the post-shift constant.
module ssc_dly_filt (
    input  logic [31:0] i_acc,
    input  logic [15:0] i_ticks,
    input  logic [3:0]  i_shift,
    output logic [31:0] o_acc,
    output logic [15:0] o_countdown
);
    import ssc_pkg::*;

    logic [31:0] sum;
    logic [31:0] avg;

    // Add the period, take the average out, keep the remainder
    always_comb begin
        sum         = i_acc + {16'd0, i_ticks};
        avg         = sum >> i_shift;
        o_acc       = sum - avg;
        o_countdown = avg[DLY_POST_SHIFT +: 16];
    end

endmodule

FILE: src/ssc_core.sv
// Commutation state and step logic: one item processed per enable.
// Depends on ssc_pkg and ssc_dly_filt.
module ssc_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  ssc_pkg::t_in_item  i_item,
    input  ssc_pkg::t_cfg      i_cfg,
    output ssc_pkg::t_out_item o_result
);
    import ssc_pkg::*;

    logic [2:0]  r_step,     n_step;
    logic        r_run,      n_run;
    logic [15:0] r_ticks,    n_ticks;
    logic [5:0]  r_window,   n_window;
    logic        r_zc_seen,  n_zc_seen;
    logic [31:0] r_acc,      n_acc;
    logic [15:0] r_cdown,    n_cdown;
    logic [2:0]  r_sel,      n_sel;

    logic [1:0]  cause;
    logic        commutate;
    logic [15:0] ticks_inc;
    logic [5:0]  window_inc;
    logic        zc_now;
    logic [31:0] filt_acc;
    logic [15:0] filt_cdown;

    ssc_dly_filt u_dly_filt (
        .i_acc       (r_acc),
        .i_ticks     (ticks_inc),
        .i_shift     (i_cfg.dly_shift),
        .o_acc       (filt_acc),
        .o_countdown (filt_cdown)
    );

    always_comb begin
        n_step    = r_step;
        n_run     = r_run;
        n_ticks   = r_ticks;
        n_window  = r_window;
        n_zc_seen = r_zc_seen;
        n_acc     = r_acc;
        n_cdown   = r_cdown;
        n_sel     = r_sel;
        cause     = CAUSE_NONE;
        commutate = 1'b0;

        ticks_inc  = r_ticks + 16'd1;
        window_inc = WINDOW_TABLE[r_window | {5'd0, i_item.comparator_out}];
        zc_now     = r_zc_seen | window_inc[0];

        unique case (i_item.kind)
            KIND_START: begin
                n_run = 1'b1;
            end
            KIND_STOP: begin
                n_run  = 1'b0;
                n_step = STEP_OFF;
            end
            KIND_TICK: begin
                if (r_step == STEP_OFF) begin
                    if (r_run) begin
                        n_step = STEP_FIRST;
                        n_sel  = SELECT_TABLE[STEP_FIRST];
                        cause  = CAUSE_START;
                    end
                end else begin
                    n_ticks   = ticks_inc;
                    n_window  = window_inc;
                    n_zc_seen = zc_now;
                    if (zc_now) begin
                        if (r_cdown == 16'd0) begin
                            commutate = 1'b1;
                            cause     = CAUSE_ZC;
                        end else begin
                            n_cdown = r_cdown - 16'd1;
                        end
                    end
                    if (!commutate && (ticks_inc > i_cfg.max_ticks)) begin
                        commutate = 1'b1;
                        cause     = CAUSE_TIMEOUT;
                    end
                    if (commutate) begin
                        n_acc     = filt_acc;
                        n_cdown   = filt_cdown;
                        n_zc_seen = 1'b0;
                        n_ticks   = 16'd0;
                        n_window  = 6'd0;
                        n_step    = (r_step >= STEP_LAST) ? STEP_FIRST : r_step + 3'd1;
                        n_sel     = SELECT_TABLE[n_step];
                    end
                end
            end
            default: begin
                // reserved kind: no change
            end
        endcase
    end

    always_comb begin
        o_result.step              = n_step;
        o_result.gate_pattern      = GATE_TABLE[n_step];
        o_result.compare_polarity  = n_sel[2];
        o_result.compare_channel   = n_sel[1:0];
        o_result.commutation_cause = cause;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= STEP_OFF;
            r_run     <= 1'b0;
            r_ticks   <= 16'd0;
            r_window  <= 6'd0;
            r_zc_seen <= 1'b0;
            r_acc     <= 32'd0;
            r_cdown   <= 16'd0;
            r_sel     <= 3'd0;
        end else if (i_en) begin
            r_step    <= n_step;
            r_run     <= n_run;
            r_ticks   <= n_ticks;
            r_window  <= n_window;
            r_zc_seen <= n_zc_seen;
            r_acc     <= n_acc;
            r_cdown   <= n_cdown;
            r_sel     <= n_sel;
        end
    end

endmodule

FILE: src/sensorless_six_step_commutator.sv
// Top level of the sensorless six-step commutator: handshake, input and
// result registers, configuration registers. Depends on ssc_pkg, ssc_core.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one item per
//   control event: a tick with a back-EMF comparator sample, a start request
//   or a stop. Every item gives exactly one result item on the output channel
//   (o_out_valid / i_out_stall / o_out_item): step, gate enables, comparator
//   channel and polarity, and the cause of any commutation.
//   From acceptance to o_out_valid the item waits in an input register, the
//   commutation logic works on it and the result register captures it.
//   Throughput is one item per cycle while the receiver does not stall; the
//   core's state update (delay filter add, shift, subtract) is combinational.
//   When the receiver stalls, the result register holds its item and the
//   input register holds the next one; o_in_stall rises only when both are
//   full and the result cannot move.
//   Configuration writes (o_cfg_ready is always high) set the timeout and
//   the delay filter shift; write them only while no items are in flight.
//   Reset clears all state but the item registers: motor off at step 0, no run
//   request, counters and filter zero, timeout 4000 and filter shift 4.
module sensorless_six_step_commutator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  ssc_pkg::t_in_item                  i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output ssc_pkg::t_out_item                 o_out_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ssc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ssc_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_cfg      r_cfg;

    logic      process;
    logic      in_accept;
    t_out_item result;

    // Process the held item whenever the result register is free or draining
    assign process    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !process;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    ssc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (process),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // Input register: load on accept, drop once processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    // Result register: load on process, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out_item <= result;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_ticks <= MAX_TICKS_RST;
            r_cfg.dly_shift <= DLY_SHIFT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_MAX_TICKS) begin
                r_cfg.max_ticks <= i_cfg_data;
            end else if (i_cfg_index == CFG_DLY_SHIFT) begin
                r_cfg.dly_shift <= i_cfg_data[3:0];
            end
        end
    end

endmodule

FILE: tb/sv/commutator_checker.sv
// Checker for the sensorless six-step commutator: watches the item, result and
// register channels, predicts every result and compares it. Depends on ssc_pkg.
`timescale 1ns / 100ps

module commutator_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  ssc_pkg::t_in_item                  i_in_item,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  ssc_pkg::t_out_item                 i_out_item,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [ssc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import ssc_pkg::*;

    localparam logic [15:0] RESET_TIMEOUT = 16'd4000;
    localparam logic [3:0]  RESET_SHIFT   = 4'd4;
    localparam logic [1:0]  PHASE_U       = 2'd0;
    localparam logic [1:0]  PHASE_V       = 2'd1;
    localparam logic [1:0]  PHASE_W       = 2'd2;
    localparam int          MAX_REPORTS   = 40;

    t_out_item   expected_drive [$];

    logic [15:0] timeout_ticks;
    logic [3:0]  filter_shift;
    logic [2:0]  step_now;
    logic        run_armed;
    logic [15:0] tick_cnt;
    logic [5:0]  emf_window;
    logic        zc_latched;
    logic [31:0] delay_acc;
    logic [15:0] delay_left;
    logic        sense_rising;
    logic [1:0]  sense_phase;
    int          mismatches = 0;
    int          reports = 0;

    // Shift the window left; a falling run after two highs reads as a crossing
    function automatic logic [5:0] emf_filter(input logic [5:0] idx);
        case (idx)
            6'd24, 6'd25, 6'd26, 6'd28, 6'd40, 6'd41, 6'd42, 6'd44,
            6'd48, 6'd49, 6'd50, 6'd52, 6'd56, 6'd57, 6'd58, 6'd60,
            6'd63:   return 6'h01;
            default: return {idx[4:0], 1'b0};
        endcase
    endfunction

    function automatic logic [5:0] gates_for_step(input logic [2:0] s);
        case (s)
            3'd1:    return 6'h24;
            3'd2:    return 6'h21;
            3'd3:    return 6'h09;
            3'd4:    return 6'h18;
            3'd5:    return 6'h12;
            3'd6:    return 6'h06;
            default: return 6'h00;
        endcase
    endfunction

    // Select the floating phase and edge; step 0 keeps the last setting
    function automatic void enter_step_model(input logic [2:0] s);
        step_now = s;
        case (s)
            3'd1: begin sense_rising = 1'b0; sense_phase = PHASE_W; end
            3'd2: begin sense_rising = 1'b1; sense_phase = PHASE_V; end
            3'd3: begin sense_rising = 1'b0; sense_phase = PHASE_U; end
            3'd4: begin sense_rising = 1'b1; sense_phase = PHASE_W; end
            3'd5: begin sense_rising = 1'b0; sense_phase = PHASE_V; end
            3'd6: begin sense_rising = 1'b1; sense_phase = PHASE_U; end
            default: ;
        endcase
    endfunction

    function automatic void commutate_model();
        logic [31:0] filtered;
        delay_acc  = delay_acc + {16'd0, tick_cnt};
        filtered   = delay_acc >> filter_shift;
        delay_acc  = delay_acc - filtered;
        delay_left = filtered[18:3];
        zc_latched = 1'b0;
        tick_cnt   = 16'd0;
        emf_window = 6'd0;
        enter_step_model(step_now >= STEP_LAST ? STEP_FIRST : step_now + 3'd1);
    endfunction

    function automatic t_out_item predict_commutation(input t_in_item item);
        t_out_item  res;
        logic [1:0] cause;
        cause = CAUSE_NONE;
        case (item.kind)
            KIND_START: run_armed = 1'b1;
            KIND_STOP: begin
                run_armed = 1'b0;
                step_now  = STEP_OFF;
            end
            KIND_TICK: begin
                if (step_now == STEP_OFF) begin
                    if (run_armed) begin
                        enter_step_model(STEP_FIRST);
                        cause = CAUSE_START;
                    end
                end else begin
                    tick_cnt   = tick_cnt + 16'd1;
                    emf_window = emf_filter(emf_window | {5'd0, item.comparator_out});
                    if (emf_window[0])
                        zc_latched = 1'b1;
                    if (zc_latched) begin
                        if (delay_left == 16'd0) begin
                            commutate_model();
                            cause = CAUSE_ZC;
                        end else begin
                            delay_left = delay_left - 16'd1;
                        end
                    end
                    if (cause == CAUSE_NONE && tick_cnt > timeout_ticks) begin
                        commutate_model();
                        cause = CAUSE_TIMEOUT;
                    end
                end
            end
            default: ;  // unused kind: no state change
        endcase
        res.step              = step_now;
        res.gate_pattern      = gates_for_step(step_now);
        res.compare_polarity  = sense_rising;
        res.compare_channel   = sense_phase;
        res.commutation_cause = cause;
        return res;
    endfunction

    function automatic bit field_ok(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
        if (got === want)
            return 1'b1;
        if (reports < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        reports++;
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        bit        ok;
        if (!i_rst_n) begin
            timeout_ticks = RESET_TIMEOUT;
            filter_shift  = RESET_SHIFT;
            step_now      = STEP_OFF;
            run_armed     = 1'b0;
            tick_cnt      = 16'd0;
            emf_window    = 6'd0;
            zc_latched    = 1'b0;
            delay_acc     = 32'd0;
            delay_left    = 16'd0;
            sense_rising  = 1'b0;
            sense_phase   = PHASE_U;
            expected_drive.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAX_TICKS: timeout_ticks = i_cfg_data;
                    CFG_DLY_SHIFT: filter_shift  = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_drive.size() == 0) begin
                    if (reports < MAX_REPORTS)
                        $display("%0t: result with none expected, expected nothing, actual %h",
                                 $time, i_out_item);
                    reports++;
                    mismatches++;
                end else begin
                    want = expected_drive.pop_front();
                    ok = 1'b1;
                    ok &= field_ok("step", 8'(want.step), 8'(i_out_item.step));
                    ok &= field_ok("gate_pattern", 8'(want.gate_pattern),
                                   8'(i_out_item.gate_pattern));
                    ok &= field_ok("compare_polarity", 8'(want.compare_polarity),
                                   8'(i_out_item.compare_polarity));
                    ok &= field_ok("compare_channel", 8'(want.compare_channel),
                                   8'(i_out_item.compare_channel));
                    ok &= field_ok("commutation_cause", 8'(want.commutation_cause),
                                   8'(i_out_item.commutation_cause));
                    if (!ok)
                        mismatches++;
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_drive.push_back(predict_commutation(i_in_item));
            o_pending <= expected_drive.size();
        end
        o_fail_count <= mismatches;
    end

endmodule

FILE: tb/sv/tb_sensorless_six_step_commutator.sv
// Testbench top for the sensorless six-step commutator: clock, reset, item and
// register stimulus, receiver stalls and verdict. Depends on ssc_pkg,
// commutator_checker and the block itself.
`timescale 1ns / 100ps

module tb_sensorless_six_step_commutator;
    import ssc_pkg::*;

    // The fourth kind code has no meaning; the block must ignore it
    localparam logic [1:0] KIND_IGNORED = 2'd3;
    // Cycles without any accepted item, taken result or write before giving up
    localparam int         STALL_LIMIT  = 3000;
    localparam int         PHASE_ITEMS  = 100;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending;

    // Stimulus shaping state
    int unsigned           quiet_left = 0;
    int unsigned           high_left = 0;
    int unsigned           low_left = 0;
    int                    idle_cycles = 0;

    sensorless_six_step_commutator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    commutator_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Pick the idle gap before the next item: mostly none or short, now and
    // then long, with occasional stretches of back-to-back items.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (quiet_left != 0) begin
            quiet_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Comparator waveform: a run of highs then a run of lows, so that the
    // falling edge after the highs reads as a zero crossing. Long low runs
    // let the timeout fire; a few flipped samples add noise.
    function automatic logic next_sample();
        logic s;
        if (high_left == 0 && low_left == 0) begin
            high_left = $urandom_range(1, 6);
            low_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 8);
        end
        if (high_left != 0) begin
            s = 1'b1;
            high_left--;
        end else begin
            s = 1'b0;
            low_left--;
        end
        if ($urandom_range(0, 19) == 0)
            s = ~s;
        return s;
    endfunction

    // Offer one item and hold it until the block takes it. Valid stays high
    // into the next call when no gap follows, so it is never toggled twice
    // in one step.
    task automatic send_item(input logic [1:0] kind, input logic cmp);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{kind, cmp};
        do @(posedge clk); while (in_stall);
    endtask

    // Write a register once every result is home; the block is idle then
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Hand-picked opening under the reset settings: tick and unused kind
    // while off, repeated start, entry on the next tick, a clean crossing,
    // stop while running, re-entry without clearing the window.
    task automatic drive_directed();
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_IGNORED, 1'b1);
        send_item(KIND_STOP, 1'b0);
        send_item(KIND_START, 1'b0);
        send_item(KIND_START, 1'b1);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_IGNORED, 1'b0);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_STOP, 1'b1);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_START, 1'b0);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_TICK, 1'b0);
    endtask

    // Run the motor: mostly ticks with a plausible back-EMF pattern, a few
    // stops followed soon by a restart, and stray unused kinds that do not
    // count towards the item total.
    task automatic run_motor(input int n);
        int          sent;
        int unsigned roll;
        bit          stopped;
        sent    = 1;
        stopped = 1'b0;
        send_item(KIND_START, 1'($urandom_range(0, 1)));
        while (sent < n) begin
            roll = $urandom_range(0, 199);
            if (stopped && roll < 50) begin
                send_item(KIND_START, 1'($urandom_range(0, 1)));
                stopped = 1'b0;
                sent++;
            end else if (roll < 3) begin
                send_item(KIND_STOP, 1'($urandom_range(0, 1)));
                stopped = 1'b1;
                sent++;
            end else if (roll < 6) begin
                send_item(KIND_START, 1'($urandom_range(0, 1)));
                stopped = 1'b0;
                sent++;
            end else if (roll < 9) begin
                send_item(KIND_IGNORED, 1'($urandom_range(0, 1)));
            end else begin
                send_item(KIND_TICK, next_sample());
                sent++;
            end
        end
    endtask

    // Set both registers, then run; the shift write carries junk above bit 3
    task automatic run_phase(input logic [15:0] max_ticks, input logic [3:0] shift);
        write_register(CFG_MAX_TICKS, max_ticks);
        write_register(CFG_DLY_SHIFT, {12'($urandom_range(0, 4095)), shift});
        run_motor(PHASE_ITEMS);
    endtask

    // Main stimulus: reset, directed opening, then phases over the extremes
    // of both registers and a couple of random settings.
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        drive_directed();
        run_phase(16'd0, 4'd0);
        run_phase(16'd65534, 4'd15);
        run_phase(16'd40, 4'd0);
        run_phase(16'd120, 4'd15);
        run_phase(16'($urandom_range(5, 300)), 4'($urandom_range(0, 15)));
        run_phase(16'($urandom_range(5, 300)), 4'($urandom_range(0, 15)));

        // Drain: wait for every result, then let any stragglers arrive
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0) begin
            $display("sensorless_six_step_commutator verification clean");
        end else begin
            $display("sensorless_six_step_commutator verification failed");
        end
        $finish;
    end

    // Receiver: alternate flowing and stalled runs, mostly short, with the
    // odd long stall and long free-flowing stretch. No run is empty, so stall
    // changes at most once per step.
    initial begin : receiver
        int unsigned run;
        forever begin
            run = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 4);
            out_stall <= 1'b0;
            repeat (run) @(posedge clk);
            run = ($urandom_range(0, 14) == 0) ? $urandom_range(15, 50)
                                               : $urandom_range(1, 3);
            out_stall <= 1'b1;
            repeat (run) @(posedge clk);
        end
    end

    // Watchdog: give up when nothing has moved on any channel for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("sensorless_six_step_commutator verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
